// ----- sv/wac_pkg.sv -----
// Package: shared types and constants of the waypoint approach controller.
`default_nettype none
package wac_pkg;
    localparam int unsigned SETTLE_LIMIT = 5;
    localparam int unsigned STRAY_LIMIT  = 10;
    localparam int unsigned BRAKE_TICKS  = 5;

    localparam logic [1:0] KIND_NORMAL   = 2'd0;
    localparam logic [1:0] KIND_BRAKE    = 2'd1;
    localparam logic [1:0] KIND_FINISHED = 2'd2;

    localparam logic [2:0] REG_TARGET_X       = 3'd0;
    localparam logic [2:0] REG_TARGET_Y       = 3'd1;
    localparam logic [2:0] REG_TARGET_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_TARGET_HEADING = 3'd3;
    localparam logic [2:0] REG_HOME_HEIGHT    = 3'd4;
    localparam logic [2:0] REG_SPEED_LIMIT    = 3'd5;
    localparam logic [2:0] REG_POS_TOL        = 3'd6;
    localparam logic [2:0] REG_HEAD_TOL       = 3'd7;

    localparam int unsigned SQRT_STEPS = 25;
    localparam int unsigned DIV_STEPS  = 16;

    typedef struct packed {
        logic load;
        logic sq_x;
        logic sq_y;
        logic sum;
        logic sqrt_step;
        logic div_setup;
        logic div_step;
        logic div_store;
        logic axis;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic norm;
        logic last;
        logic out_free;
    } t_status;
endpackage
`default_nettype wire

// ----- sv/wac_ctrl.sv -----
// Controller: sequences square, root and divide steps for one transaction.
`default_nettype none
module wac_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire wac_pkg::t_status i_status,
    output wac_pkg::t_cmd         o_cmd
);
    import wac_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_SQ_X, ST_SQ_Y, ST_SUM, ST_SQRT,
        ST_DSET, ST_DRUN, ST_DSTORE, ST_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_axis, n_axis;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECIDE;
                end
            end
            ST_DECIDE: n_state = i_status.norm ? ST_SQ_X : ST_OUT;
            ST_SQ_X: begin
                o_cmd.sq_x = 1'b1;
                n_state    = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                o_cmd.sq_y = 1'b1;
                n_state    = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.last) begin
                    n_axis  = 1'b0;
                    n_state = ST_DSET;
                end
            end
            ST_DSET: begin
                o_cmd.div_setup = 1'b1;
                n_state         = ST_DRUN;
            end
            ST_DRUN: begin
                o_cmd.div_step = 1'b1;
                if (i_status.last) n_state = ST_DSTORE;
            end
            ST_DSTORE: begin
                o_cmd.div_store = 1'b1;
                if (r_axis) begin
                    n_state = ST_OUT;
                end else begin
                    n_axis  = 1'b1;
                    n_state = ST_DSET;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end
endmodule
`default_nettype wire

// ----- sv/wac_dpath.sv -----
// Datapath: configuration, counters, errors, square root, divider, output register.
`default_nettype none
module wac_dpath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [23:0]         i_cfg_data,
    input  wire logic                i_restart,
    input  wire logic signed [23:0]  i_pos_x,
    input  wire logic signed [23:0]  i_pos_y,
    input  wire logic signed [23:0]  i_measured_height,
    input  wire logic signed [14:0]  i_heading,
    input  wire wac_pkg::t_cmd       i_cmd,
    output wac_pkg::t_status         o_status,
    input  wire logic                i_ready,
    output logic                     o_valid,
    output logic [1:0]               o_kind,
    output logic signed [23:0]       o_cmd_x,
    output logic signed [23:0]       o_cmd_y,
    output logic signed [23:0]       o_cmd_z,
    output logic signed [14:0]       o_cmd_yaw,
    output logic                     o_done_res
);
    import wac_pkg::*;

    logic signed [23:0] r_tx, r_ty, r_th, r_home;
    logic signed [14:0] r_tyaw;
    logic [15:0]        r_spd, r_ptol;
    logic [13:0]        r_htol;

    logic [3:0] r_settle, r_stray, r_brake;
    logic       r_fin;
    logic [3:0] n_settle, n_stray, n_brake;
    logic       n_fin;
    logic [1:0] n_kind, r_kind;

    logic signed [24:0] r_dx, r_dy;
    logic [49:0] r_prod, r_acc, r_rad;
    logic [26:0] r_rem;
    logic [24:0] r_root;
    logic [40:0] r_dprod;
    logic [24:0] r_drem;
    logic [15:0] r_quo;
    logic [4:0]  r_cnt;
    logic signed [23:0] r_cx, r_cy;

    logic signed [24:0] dx, dy;
    logic signed [25:0] dz;
    logic signed [15:0] dyaw;
    logic [24:0] adx, ady;
    logic [25:0] adz;
    logic [15:0] adyaw;
    logic        inb;

    logic [24:0] ax_e;
    logic signed [24:0] ax_s;
    logic [28:0] sq_rem, sq_trial;
    logic [25:0] d_rem, d_len;
    logic [40:0] d_prod;
    logic signed [24:0] ax_cmd;

    always_comb begin
        dx    = 25'(r_tx) - 25'(i_pos_x);
        dy    = 25'(r_ty) - 25'(i_pos_y);
        dz    = 26'(r_th) - (26'(i_measured_height) - 26'(r_home));
        dyaw  = 16'(i_heading) - 16'(r_tyaw);
        adx   = dx[24] ? 25'(-dx) : 25'(dx);
        ady   = dy[24] ? 25'(-dy) : 25'(dy);
        adz   = dz[25] ? 26'(-dz) : 26'(dz);
        adyaw = dyaw[15] ? 16'(-dyaw) : 16'(dyaw);
        inb   = (adx < 25'(r_ptol)) && (ady < 25'(r_ptol)) && (adz < 26'(r_ptol))
                && (adyaw < 16'(r_htol));
    end

    always_comb begin
        n_settle = r_settle;
        n_stray  = r_stray;
        n_brake  = r_brake;
        n_fin    = r_fin;
        if (i_restart) begin
            n_settle = '0;
            n_stray  = '0;
            n_brake  = '0;
            n_fin    = 1'b0;
        end
        if (n_fin || (n_brake > 4'(BRAKE_TICKS))) begin
            n_fin  = 1'b1;
            n_kind = KIND_FINISHED;
        end else if (n_brake != '0) begin
            n_brake = (n_brake == 4'hf) ? n_brake : n_brake + 4'd1;
            n_kind  = KIND_BRAKE;
        end else begin
            n_kind = KIND_NORMAL;
            if (inb) begin
                n_settle = (n_settle == 4'hf) ? n_settle : n_settle + 4'd1;
            end else if (n_settle != '0) begin
                n_stray = (n_stray == 4'hf) ? n_stray : n_stray + 4'd1;
            end
            if (n_stray > 4'(STRAY_LIMIT)) begin
                n_settle = '0;
                n_stray  = '0;
            end
            if (n_settle > 4'(SETTLE_LIMIT)) n_brake = 4'd1;
        end
    end

    always_comb begin
        ax_s     = i_cmd.axis ? r_dy : r_dx;
        ax_e     = ax_s[24] ? 25'(-ax_s) : 25'(ax_s);
        sq_rem   = {r_rem[26:0], r_rad[49:48]};
        sq_trial = {2'b00, r_root, 2'b01};
        d_rem    = {r_drem, r_dprod[40]};
        d_len    = {1'b0, r_root};
        d_prod   = 41'(ax_e) * 41'(r_spd);
        if (ax_e < 25'(r_spd)) begin
            ax_cmd = ax_s;
        end else if (r_root == '0) begin
            ax_cmd = '0;
        end else begin
            ax_cmd = ax_s[24] ? -25'(r_quo) : 25'(r_quo);
        end
    end

    assign o_status.norm     = (r_kind == KIND_NORMAL);
    assign o_status.last     = (r_cnt == '0);
    assign o_status.out_free = !o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx     <= '0;
            r_ty     <= '0;
            r_th     <= 24'sd2560;
            r_tyaw   <= '0;
            r_home   <= '0;
            r_spd    <= 16'd128;
            r_ptol   <= 16'd51;
            r_htol   <= 14'd357;
            r_settle <= '0;
            r_stray  <= '0;
            r_brake  <= '0;
            r_fin    <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TARGET_X:       r_tx   <= i_cfg_data;
                    REG_TARGET_Y:       r_ty   <= i_cfg_data;
                    REG_TARGET_HEIGHT:  r_th   <= i_cfg_data;
                    REG_TARGET_HEADING: r_tyaw <= i_cfg_data[14:0];
                    REG_HOME_HEIGHT:    r_home <= i_cfg_data;
                    REG_SPEED_LIMIT:    r_spd  <= i_cfg_data[15:0];
                    REG_POS_TOL:        r_ptol <= i_cfg_data[15:0];
                    REG_HEAD_TOL:       r_htol <= i_cfg_data[13:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_settle <= n_settle;
                r_stray  <= n_stray;
                r_brake  <= n_brake;
                r_fin    <= n_fin;
            end
            if (i_cmd.out_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= n_kind;
            r_dx   <= dx;
            r_dy   <= dy;
        end
        if (i_cmd.sq_x) begin
            r_prod <= 50'(25'(r_dx[24] ? -r_dx : r_dx) * 25'(r_dx[24] ? -r_dx : r_dx));
        end
        if (i_cmd.sq_y) begin
            r_acc  <= r_prod;
            r_prod <= 50'(25'(r_dy[24] ? -r_dy : r_dy) * 25'(r_dy[24] ? -r_dy : r_dy));
        end
        if (i_cmd.sum) begin
            r_rad  <= r_acc + r_prod;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= 5'(SQRT_STEPS - 1);
        end
        if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[47:0], 2'b00};
            if (sq_rem >= sq_trial) begin
                r_rem  <= 27'(sq_rem - sq_trial);
                r_root <= {r_root[23:0], 1'b1};
            end else begin
                r_rem  <= 27'(sq_rem);
                r_root <= {r_root[23:0], 1'b0};
            end
            r_cnt <= r_cnt - 5'd1;
        end
        // The quotient fits 16 bits, so the upper product bits seed the remainder
        if (i_cmd.div_setup) begin
            r_dprod <= {d_prod[15:0], 25'd0};
            r_quo   <= '0;
            r_cnt   <= 5'(DIV_STEPS - 1);
        end
        if (i_cmd.div_step) begin
            r_dprod <= {r_dprod[39:0], 1'b0};
            r_cnt   <= r_cnt - 5'd1;
        end
        if (i_cmd.div_setup) begin
            r_drem <= d_prod[40:16];
        end else if (i_cmd.div_step) begin
            if (d_rem >= d_len) begin
                r_drem <= 25'(d_rem - d_len);
                r_quo  <= {r_quo[14:0], 1'b1};
            end else begin
                r_drem <= d_rem[24:0];
                r_quo  <= {r_quo[14:0], 1'b0};
            end
        end
        if (i_cmd.div_store) begin
            if (i_cmd.axis) r_cy <= ax_cmd[23:0];
            else            r_cx <= ax_cmd[23:0];
        end
        if (i_cmd.out_load) begin
            o_kind     <= r_kind;
            o_done_res <= (r_kind == KIND_FINISHED);
            if (r_kind == KIND_NORMAL) begin
                o_cmd_x   <= r_cx;
                o_cmd_y   <= r_cy;
                o_cmd_z   <= r_th;
                o_cmd_yaw <= r_tyaw;
            end else begin
                o_cmd_x   <= '0;
                o_cmd_y   <= '0;
                o_cmd_z   <= '0;
                o_cmd_yaw <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/waypoint_approach_controller.sv -----
// Top level: waypoint approach controller with settle, stray and brake counters.
// One transaction per control tick. A normal command runs from acceptance to
// result through the decide, x-square, y-square and sum steps, the bit-serial
// square root, the shared 16-step divider once for each axis and the output
// step; brake and finished ticks go from the decide step straight to output. One
// tick is worked at a time: a new tick is taken only once the last is loaded out.
// The next tick is taken while the result waits in the output register; a result
// still waiting when the following one is ready holds that tick at its output step.
`default_nettype none
module waypoint_approach_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_restart,
    input  wire logic signed [23:0] i_pos_x,
    input  wire logic signed [23:0] i_pos_y,
    input  wire logic signed [23:0] i_measured_height,
    input  wire logic signed [14:0] i_heading,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_kind,
    output logic signed [23:0]      o_cmd_x,
    output logic signed [23:0]      o_cmd_y,
    output logic signed [23:0]      o_cmd_z,
    output logic signed [14:0]      o_cmd_yaw,
    output logic                    o_done_res
);
    import wac_pkg::*;

    t_cmd    cmd;
    t_status status;

    wac_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    wac_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_restart         (i_restart),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_measured_height (i_measured_height),
        .i_heading         (i_heading),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_cmd_x           (o_cmd_x),
        .o_cmd_y           (o_cmd_y),
        .o_cmd_z           (o_cmd_z),
        .o_cmd_yaw         (o_cmd_yaw),
        .o_done_res        (o_done_res)
    );

    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_done_res == (o_kind == KIND_FINISHED)))
        else $error("done flag disagrees with kind");

    a_zero_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_NORMAL) |->
        (o_cmd_x == '0 && o_cmd_y == '0 && o_cmd_z == '0 && o_cmd_yaw == '0))
        else $error("nonzero command on brake or finished tick");

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_valid || i_ready))
        else $error("result overwritten before taken");
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for the waypoint approach controller: directed and random ticks.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import wac_pkg::*;

    typedef struct {
        logic              restart;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] height;
        logic signed [14:0] heading;
    } t_tick;

    typedef struct {
        logic [1:0]         kind;
        logic signed [23:0] cmd_x;
        logic signed [23:0] cmd_y;
        logic signed [23:0] cmd_z;
        logic signed [14:0] cmd_yaw;
        logic               done;
    } t_command;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = REG_TARGET_X;
    logic [23:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_restart = 1'b0;
    logic signed [23:0] i_pos_x = '0;
    logic signed [23:0] i_pos_y = '0;
    logic signed [23:0] i_measured_height = '0;
    logic signed [14:0] i_heading = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_kind;
    logic signed [23:0] o_cmd_x;
    logic signed [23:0] o_cmd_y;
    logic signed [23:0] o_cmd_z;
    logic signed [14:0] o_cmd_yaw;
    logic               o_done_res;

    waypoint_approach_controller dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor state and register copy
    logic signed [23:0] tgt_x = 0, tgt_y = 0, tgt_h = 2560, home_h = 0;
    logic signed [14:0] tgt_yaw = 0;
    logic [15:0]        speed = 128, pos_tol = 51;
    logic [13:0]        yaw_tol = 357;
    logic [3:0]         settle_cnt = 0, stray_cnt = 0, brake_cnt = 0;
    logic               finished = 0;

    t_command expected_cmds[$];
    int  mismatches = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  recv_hold = 0;
    longint cycles = 0;

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint velocity(longint e, longint s, longint unsigned len);
        longint m;
        if (mag(e) < s) return e;
        if (len == 0) return 0;
        m = longint'((unsigned'(mag(e)) * unsigned'(s)) / len);
        return e < 0 ? -m : m;
    endfunction

    function automatic logic [3:0] bump(logic [3:0] c);
        return c == 4'd15 ? c : c + 4'd1;
    endfunction

    task automatic advance_controller(t_tick t);
        t_command c;
        longint dx, dy, dz, s;
        longint unsigned len;
        c = '{KIND_NORMAL, 0, 0, 0, 0, 1'b0};
        if (t.restart) begin
            settle_cnt = 0; stray_cnt = 0; brake_cnt = 0; finished = 0;
        end
        if (finished || brake_cnt > BRAKE_TICKS) begin
            finished = 1;
            c.kind = KIND_FINISHED;
            c.done = 1'b1;
        end else if (brake_cnt > 0) begin
            brake_cnt = bump(brake_cnt);
            c.kind = KIND_BRAKE;
        end else begin
            dx = longint'(tgt_x) - longint'(t.pos_x);
            dy = longint'(tgt_y) - longint'(t.pos_y);
            dz = longint'(tgt_h) - (longint'(t.height) - longint'(home_h));
            s = longint'(speed);
            len = floor_sqrt(unsigned'(dx * dx) + unsigned'(dy * dy));
            c.cmd_x = 24'(velocity(dx, s, len));
            c.cmd_y = 24'(velocity(dy, s, len));
            c.cmd_z = tgt_h;
            c.cmd_yaw = tgt_yaw;
            if (mag(dx) < longint'(pos_tol) && mag(dy) < longint'(pos_tol) &&
                mag(dz) < longint'(pos_tol) &&
                mag(longint'(t.heading) - longint'(tgt_yaw)) < longint'(yaw_tol))
                settle_cnt = bump(settle_cnt);
            else if (settle_cnt != 0)
                stray_cnt = bump(stray_cnt);
            if (stray_cnt > STRAY_LIMIT) begin
                settle_cnt = 0; stray_cnt = 0;
            end
            if (settle_cnt > SETTLE_LIMIT) brake_cnt = 1;
        end
        expected_cmds = {expected_cmds, c};
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            i_ready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_command e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d", o_kind);
            end else begin
                e = expected_cmds.pop_front();
                if (o_kind !== e.kind || o_cmd_x !== e.cmd_x || o_cmd_y !== e.cmd_y ||
                    o_cmd_z !== e.cmd_z || o_cmd_yaw !== e.cmd_yaw ||
                    o_done_res !== e.done) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"exp k=%0d x=%0d y=%0d z=%0d yaw=%0d d=%0b ",
                                  "got k=%0d x=%0d y=%0d z=%0d yaw=%0d d=%0b"},
                                 e.kind, e.cmd_x, e.cmd_y, e.cmd_z, e.cmd_yaw, e.done,
                                 o_kind, o_cmd_x, o_cmd_y, o_cmd_z, o_cmd_yaw, o_done_res);
                end
            end
        end
    end

    task automatic send_tick(t_tick t);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_restart = t.restart;
        i_pos_x = t.pos_x;
        i_pos_y = t.pos_y;
        i_measured_height = t.height;
        i_heading = t.heading;
        do @(posedge i_clk); while (!o_ready);
        advance_controller(t);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_TARGET_X:       tgt_x = val;
            REG_TARGET_Y:       tgt_y = val;
            REG_TARGET_HEIGHT:  tgt_h = val;
            REG_TARGET_HEADING: tgt_yaw = val[14:0];
            REG_HOME_HEIGHT:    home_h = val;
            REG_SPEED_LIMIT:    speed = val[15:0];
            REG_POS_TOL:        pos_tol = val[15:0];
            default:            yaw_tol = val[13:0];
        endcase
    endtask

    function automatic logic signed [23:0] near(logic signed [23:0] c, int spread);
        longint v;
        v = longint'(c) + $signed($urandom_range(0, 2 * spread)) - spread;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return 24'(v);
    endfunction

    function automatic logic signed [14:0] rand_heading();
        return 15'($signed($urandom_range(0, 25736)) - 12868);
    endfunction

    function automatic t_tick noisy_tick();
        t_tick t;
        t.restart = ($urandom_range(0, 19) == 0);
        t.pos_x = 24'($urandom);
        t.pos_y = 24'($urandom);
        t.height = 24'($urandom);
        t.heading = rand_heading();
        return t;
    endfunction

    function automatic t_tick approach_tick(int spread);
        t_tick t;
        t.restart = 1'b0;
        t.pos_x = near(tgt_x, spread);
        t.pos_y = near(tgt_y, spread);
        t.height = near(24'(longint'(tgt_h) + longint'(home_h)), spread);
        t.heading = 15'(near(24'(tgt_yaw), spread / 4 + 1));
        if (t.heading > 12868) t.heading = 12868;
        if (t.heading < -12868) t.heading = -12868;
        return t;
    endfunction

    task automatic test_field_extremes;
        send_tick('{1'b1, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 15'sd12868});
        send_tick('{1'b0, 24'sh800000, 24'sh7FFFFF, 24'sh800000, -15'sd12868});
        send_tick('{1'b0, 24'sd0, 24'sd0, 24'sd2560, 15'sd0});
        send_tick('{1'b0, 24'sd100, -24'sd50, 24'sd2500, 15'sd100});
        send_tick('{1'b0, -24'sd1, 24'sd1, -24'sd1, -15'sd1});
        drain();
    endtask

    task automatic test_config_extremes;
        write_reg(REG_TARGET_X, 24'h7FFFFF);
        write_reg(REG_TARGET_Y, 24'h800000);
        write_reg(REG_TARGET_HEIGHT, 24'h800000);
        write_reg(REG_TARGET_HEADING, 24'(-12868));
        write_reg(REG_HOME_HEIGHT, 24'h7FFFFF);
        write_reg(REG_SPEED_LIMIT, 24'hFFFF);
        write_reg(REG_POS_TOL, 24'hFFFF);
        write_reg(REG_HEAD_TOL, 24'd12868);
        send_tick('{1'b1, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 15'sd12868});
        send_tick('{1'b0, 24'sh7FFFFF, 24'sh800000, 24'sd0, -15'sd12868});
        drain();
        write_reg(REG_TARGET_X, 24'd0);
        write_reg(REG_TARGET_Y, 24'd0);
        write_reg(REG_SPEED_LIMIT, 24'd0);
        write_reg(REG_POS_TOL, 24'd0);
        write_reg(REG_HEAD_TOL, 24'd0);
        send_tick('{1'b1, 24'sd0, 24'sd0, 24'sd0, 15'sd0});
        send_tick('{1'b0, 24'sd3, -24'sd4, 24'sd0, 15'sd0});
        drain();
    endtask

    task automatic test_settle_brake_finish;
        write_reg(REG_TARGET_X, 24'd5000);
        write_reg(REG_TARGET_Y, 24'(-3000));
        write_reg(REG_TARGET_HEIGHT, 24'd2560);
        write_reg(REG_TARGET_HEADING, 24'd1000);
        write_reg(REG_HOME_HEIGHT, 24'd40);
        write_reg(REG_SPEED_LIMIT, 24'd128);
        write_reg(REG_POS_TOL, 24'd51);
        write_reg(REG_HEAD_TOL, 24'd357);
        send_tick('{1'b1, 24'sd0, 24'sd0, 24'sd0, 15'sd0});
        send_tick(approach_tick(20));
        send_tick('{1'b0, 24'sd0, 24'sd0, 24'sd0, 15'sd0});
        repeat (16) send_tick(approach_tick(20));
        send_tick('{1'b1, 24'sd5000, -24'sd3000, 24'sd2600, 15'sd1000});
        drain();
    endtask

    task automatic run_random(int count);
        int spread;
        for (int k = 0; k < count; k++) begin
            if (k % 60 == 0) begin
                drain();
                write_reg(REG_TARGET_X, 24'($signed($urandom_range(0, 200000)) - 100000));
                write_reg(REG_TARGET_Y, 24'($signed($urandom_range(0, 200000)) - 100000));
                write_reg(REG_TARGET_HEIGHT, 24'($urandom_range(0, 20000)));
                write_reg(REG_TARGET_HEADING, 24'(rand_heading()));
                write_reg(REG_HOME_HEIGHT, 24'($signed($urandom_range(0, 2000)) - 1000));
                write_reg(REG_SPEED_LIMIT, 24'($urandom_range(0, 3) == 0 ?
                          $urandom_range(0, 65535) : $urandom_range(0, 400)));
                write_reg(REG_POS_TOL, 24'($urandom_range(0, 300)));
                write_reg(REG_HEAD_TOL, 24'($urandom_range(0, 1500)));
                send_tick('{1'b1, tgt_x, tgt_y, tgt_h, tgt_yaw});
            end
            if (k % 200 == 100) recv_hold = 400;
            spread = $urandom_range(0, 3) == 0 ? 2000 : pos_tol;
            send_tick($urandom_range(0, 9) < 2 ? noisy_tick() : approach_tick(spread));
        end
        drain();
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        send_idle_pct = 21; recv_idle_pct = 52;
        test_field_extremes();
        test_config_extremes();
        test_settle_brake_finish();
        run_random(270);
        send_idle_pct = 52; recv_idle_pct = 21;
        run_random(270);
        send_idle_pct = 0; recv_idle_pct = 0;
        run_random(270);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
